// ===== rtl/mmdd_pkg.sv =====
package mmdd_pkg;

    // Item and state widths.
    localparam int DATA_W = 24;
    localparam int SUM_W  = 30;

    // Number of samples held in the ring.
    localparam int WINDOW = 45;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Sample offset and threshold reset value.
    localparam logic [DATA_W-1:0] SAMPLE_OFFSET   = 24'h7FFFFF;
    localparam logic [DATA_W-1:0] RAW_MOST_NEG    = 24'h800000;
    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 24'd350000;

    // Configuration port layout.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    // Mean by reciprocal multiplication: with the shift set to the sum width plus
    // the bit length of the window, the rounded-up reciprocal gives the exact
    // truncated quotient for every sum value.
    localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW);
    localparam longint unsigned MEAN_RECIP =
        ((64'd1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    // Write request into the sample ring.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } ring_wr_t;

    // Truncated window mean, limited to the sample width.
    function automatic logic [DATA_W-1:0] window_mean_of(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
        return prod[MEAN_SHIFT +: DATA_W];
    endfunction

endpackage

// ===== rtl/mmdd_ring.sv =====
module mmdd_ring (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mmdd_pkg::ring_wr_t       wr,
    input  logic [mmdd_pkg::IDX_W-1:0]  rd_addr,
    output logic [mmdd_pkg::DATA_W-1:0] rd_data
);
    import mmdd_pkg::*;

    logic [DATA_W-1:0] mem [WINDOW];
    logic [DATA_W-1:0] rd_raw_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              byp_reg;

    // Sample memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_raw_reg   <= mem[rd_addr];
        byp_data_reg <= wr.data;
    end

    // A write to the address being read in the same cycle is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_raw_reg;

endmodule

// ===== rtl/moving_mean_deviation_detector.sv =====
// Moving-mean deviation detector. Each signed 24-bit reading on the input stream is
// offset by 0x7FFFFF (the most negative reading clamps to zero) and checked against
// the truncated mean of the last 45 stored samples; one result item leaves for every
// input item. While the window fills, samples are stored and summed and the result
// shows filling with zero mean and deviation. Once full, a deviation strictly above
// deviation_threshold (APB register at address 0, reset 350000) raises detect, drops
// the sample and restarts the fill; otherwise every second checked sample replaces the
// oldest ring entry. The block accepts one item per clock cycle while the result stream
// is not stalled. An accepted item sits in the input register while the mean multiplier,
// compare and ring update feed the result register; a stall on the result stream holds
// the item in the input register. The ring is a 45-entry memory whose next read is
// fetched one item ahead, with write forwarding.
module moving_mean_deviation_detector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream. tdata: sample_raw[23:0].
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mmdd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Result stream. tdata: detect[0], window_mean[24:1], deviation[48:25], zero pad.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mmdd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: filling[0].
    output logic                                  m_axis_tuser,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mmdd_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mmdd_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [mmdd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import mmdd_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] sample_in;

    logic [DATA_W-1:0] threshold_reg;
    logic [DATA_W-1:0] threshold_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [IDX_W-1:0]  oldest_reg;
    logic [IDX_W-1:0]  oldest_next;
    logic              skip_reg;
    logic              skip_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              detect_reg;
    logic              filling_reg;
    logic [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0] dev_reg;

    logic              advance;
    logic              full;
    logic              cfg_write;
    logic [DATA_W-1:0] mean_c;
    logic [DATA_W-1:0] dev_c;
    logic              detect_c;
    logic [DATA_W-1:0] oldest_data;
    logic [IDX_W-1:0]  rd_addr;
    ring_wr_t          ring_wr;

    // Handshakes: the input register moves on whenever the result register is free.
    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_valid_next  = s_axis_tvalid && s_axis_tready ? 1'b1 :
                            (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Offset the reading; the most negative reading would go below zero and clamps.
    assign sample_in = (s_axis_tdata[DATA_W-1:0] == RAW_MOST_NEG) ? '0 :
                       s_axis_tdata[DATA_W-1:0] + SAMPLE_OFFSET;

    // Configuration register access.
    assign pready         = 1'b1;
    assign cfg_write      = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
    assign threshold_next = cfg_write ? pwdata[DATA_W-1:0] : threshold_reg;
    assign prdata         = (paddr[2] == REG_THRESHOLD) ?
                            APB_DATA_W'(threshold_reg) : '0;

    // Mean, deviation and the threshold check.
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign mean_c   = window_mean_of(sum_reg);
    assign dev_c    = (sample_reg >= mean_c) ? (sample_reg - mean_c) : (mean_c - sample_reg);
    assign detect_c = (dev_c > threshold_reg);

    // Window state update for the item in the input register.
    always_comb
    begin
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        skip_next    = skip_reg;
        ring_wr.en   = 1'b0;
        ring_wr.addr = oldest_reg;
        ring_wr.data = sample_reg;
        if (advance)
        begin
            if (!full)
            begin
                ring_wr.en   = 1'b1;
                ring_wr.addr = fill_reg[IDX_W-1:0];
                sum_next     = sum_reg + SUM_W'(sample_reg);
                fill_next    = fill_reg + CNT_W'(1);
                oldest_next  = '0;
            end
            else
            begin
                skip_next = !skip_reg;
                if (detect_c)
                begin
                    sum_next    = '0;
                    fill_next   = '0;
                    oldest_next = '0;
                end
                else if (!skip_reg)
                begin
                    ring_wr.en  = 1'b1;
                    sum_next    = sum_reg - SUM_W'(oldest_data) + SUM_W'(sample_reg);
                    oldest_next = (oldest_reg == IDX_W'(WINDOW - 1)) ? '0 :
                                  oldest_reg + IDX_W'(1);
                end
            end
        end
    end

    // The ring read runs one item ahead at the next oldest entry.
    assign rd_addr = oldest_next;

    mmdd_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ring_wr),
        .rd_addr (rd_addr),
        .rd_data (oldest_data)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            threshold_reg <= threshold_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            skip_reg      <= skip_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= sample_in;
        end
        if (advance)
        begin
            filling_reg <= !full;
            detect_reg  <= full && detect_c;
            mean_reg    <= full ? mean_c : '0;
            dev_reg     <= full ? dev_c : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = filling_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({dev_reg, mean_reg, detect_reg});

endmodule

// ===== rtl/mmdd_checker.sv =====
module mmdd_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [mmdd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  m_axis_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mmdd_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mmdd_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic [mmdd_pkg::APB_DATA_W-1:0]       prdata,
    input  logic                                  pready
);
    import mmdd_pkg::*;

    // A fill result carries no detection, mean or deviation.
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("fill result carries a non-zero payload");

    // A detection needs a deviation above a threshold that is at least zero.
    a_detect_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[48:25] != '0))
        else $error("detection with zero deviation");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tuser)))
        else $error("result item changed while stalled");

    // A threshold write is read back in the following cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) |=>
        (!(psel && !pwrite && paddr[2] == REG_THRESHOLD) ||
         prdata == APB_DATA_W'($past(pwdata[DATA_W-1:0]))))
        else $error("threshold readback mismatch");

endmodule

bind moving_mean_deviation_detector mmdd_checker u_mmdd_checker (.*);

// ===== sim/moving_mean_deviation_detector_tb.sv =====
module moving_mean_deviation_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmdd_pkg::*;

    // Register byte addresses on the configuration port.
    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = 3'd4;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 6;

    // Fields of one result item.
    typedef struct packed {
        logic              detect;
        logic              filling;
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] dev;
    } check_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    moving_mean_deviation_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predicted detector state and configuration.
    logic [DATA_W-1:0] ring_samples [WINDOW];
    logic [SUM_W-1:0]  ring_total;
    int                samples_held;
    int                oldest_slot;
    logic              skip_update;
    logic [DATA_W-1:0] threshold;

    // Readings waiting to be sent and results waiting to arrive.
    logic [IN_TDATA_W-1:0] pending_readings [$];
    check_result_t         awaited_results [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    int  send_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    check_result_t got;
    check_result_t want;

    // Offsets a reading, clamping the most negative one to zero.
    function automatic logic [DATA_W-1:0] offset_reading(input logic [DATA_W-1:0] raw);
        int v;
        v = int'($signed(raw)) + int'(SAMPLE_OFFSET);
        if (v < 0)
            v = 0;
        return v[DATA_W-1:0];
    endfunction

    // Works out the result of one reading and advances the predicted state.
    function automatic check_result_t judge_reading(input logic [DATA_W-1:0] raw);
        check_result_t res;
        logic [DATA_W-1:0] s;
        s = offset_reading(raw);
        res = '0;
        if (samples_held < WINDOW)
        begin
            ring_samples[samples_held] = s;
            ring_total = ring_total + SUM_W'(s);
            samples_held++;
            oldest_slot = 0;
            res.filling = 1'b1;
        end
        else
        begin
            res.mean = DATA_W'(ring_total / WINDOW);
            res.dev = (s >= res.mean) ? s - res.mean : res.mean - s;
            if (res.dev > threshold)
            begin
                // Outlier: drop it and start the window again.
                res.detect = 1'b1;
                ring_total = '0;
                samples_held = 0;
                oldest_slot = 0;
            end
            else if (!skip_update)
            begin
                ring_total = ring_total - SUM_W'(ring_samples[oldest_slot]) + SUM_W'(s);
                ring_samples[oldest_slot] = s;
                oldest_slot = (oldest_slot + 1 >= WINDOW) ? 0 : oldest_slot + 1;
            end
            skip_update = ~skip_update;
        end
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // A reading scattered about a level, with some outliers and extremes.
    function automatic logic [DATA_W-1:0] make_reading(input int level, input int spread);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 6)
            return DATA_W'($urandom);
        else if (r < 9)
            return RAW_MOST_NEG;
        else if (r < 12)
            return 24'h7FFFFF;
        v = level + $urandom_range(0, 2 * spread) - spread;
        if (v < -8388608)
            v = -8388608;
        if (v > 8388607)
            v = 8388607;
        return v[DATA_W-1:0];
    endfunction

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Input driver: records each accepted item and offers the next one.
    always
    begin
        @(posedge clk);
        if (s_axis_tvalid && s_axis_tready)
        begin
            awaited_results.push_back(judge_reading(s_axis_tdata));
            void'(pending_readings.pop_front());
            send_gap = pick_gap();
        end
        @(negedge clk);
        if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap--;
        end
        else if (rst_n && pending_readings.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_readings[0];
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Result monitor and receiver stalls.
    always
    begin
        @(posedge clk);
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got.detect = m_axis_tdata[0];
            got.mean = m_axis_tdata[24:1];
            got.dev = m_axis_tdata[48:25];
            got.filling = m_axis_tuser;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.detect !== want.detect)
                begin
                    $error("detect: expected %0d, actual %0d", want.detect, got.detect);
                    mismatches++;
                end
                if (got.filling !== want.filling)
                begin
                    $error("filling: expected %0d, actual %0d", want.filling, got.filling);
                    mismatches++;
                end
                if (got.mean !== want.mean)
                begin
                    $error("window_mean: expected %0d, actual %0d", want.mean, got.mean);
                    mismatches++;
                end
                if (got.dev !== want.dev)
                begin
                    $error("deviation: expected %0d, actual %0d", want.dev, got.dev);
                    mismatches++;
                end
            end
        end
        @(negedge clk);
        // One long hold-off early on, so the block fills up and stalls its input.
        if (!long_hold_done && results_seen >= 60)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            hold_left = pick_gap();
        end
    end

    // Configuration writes: setup cycle, then access cycle.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            threshold = value[DATA_W-1:0];
    endtask

    // Reads the threshold back and compares it with the predicted value.
    task automatic check_threshold();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_THRESHOLD;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[DATA_W-1:0] !== threshold)
        begin
            $error("deviation_threshold: expected %0d, actual %0d", threshold,
                   prdata[DATA_W-1:0]);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every item has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_readings.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Queues random readings scattered at the current threshold.
    task automatic queue_random(input int count);
        int level;
        int spread;
        level = $urandom_range(0, 14000000) - 7000000;
        spread = (int'(threshold) > 6000000) ? 8388607 : int'(threshold) * 5 / 4 + 16;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 2)
                level = $urandom_range(0, 14000000) - 7000000;
            pending_readings.push_back(make_reading(level, spread));
        end
    endtask

    // Stimulus.
    initial
    begin
        threshold = THRESHOLD_RESET;
        ring_total = '0;
        samples_held = 0;
        oldest_slot = 0;
        skip_update = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_threshold();

        // Field extremes during the first fill, the clamped reading among them.
        pending_readings.push_back(RAW_MOST_NEG);
        pending_readings.push_back(24'h800001);
        pending_readings.push_back(24'hFFFFFF);
        pending_readings.push_back(24'h000000);
        pending_readings.push_back(24'h000001);
        pending_readings.push_back(24'h7FFFFF);
        pending_readings.push_back(24'h7FFFFE);
        pending_readings.push_back(24'h555555);
        pending_readings.push_back(24'hAAAAAA);
        pending_readings.push_back(RAW_MOST_NEG);
        queue_random(190);
        wait_drained();

        // Zero threshold: any deviation at all is an outlier; no idling here.
        write_reg(ADDR_THRESHOLD, 32'd0);
        check_threshold();
        no_idle = 1'b1;
        queue_random(100);
        wait_drained();
        no_idle = 1'b0;

        // Largest threshold, upper bits of the write ignored; a write to a
        // spare address must leave it alone.
        write_reg(ADDR_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(ADDR_SPARE, 32'd5);
        check_threshold();
        queue_random(150);
        wait_drained();

        // A few moderate thresholds.
        repeat (3)
        begin
            write_reg(ADDR_THRESHOLD, $urandom_range(1000, 3000000));
            check_threshold();
            queue_random(100);
            wait_drained();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
